@@ src/rapqt_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the range-add / point-query segment tree.
// No dependencies; used by rapqt_cell and range_add_point_query_tree_core.
package rapqt_pkg;

    // Widths fixed by the item format.
    localparam int POS_W = 11;
    localparam int AMT_W = 64;

    // Bit offsets of the fields inside the input tdata word.
    localparam int LEFT_LSB  = 0;
    localparam int RIGHT_LSB = LEFT_LSB + POS_W;
    localparam int AMT_LSB   = RIGHT_LSB + POS_W;
    localparam int IN_DATA_W = ((AMT_LSB + AMT_W + 7) / 8) * 8;

    // Item kinds as carried on tuser.
    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_ADD  = 2'd1,
        OP_GET  = 2'd2
    } op_t;

    localparam logic [1:0] KIND_UNUSED = 2'd3;

    // Control word that travels down the chain of level cells with each item.
    typedef struct packed {
        logic valid;   // an item occupies this slot
        op_t  op;
        logic side;    // add pass: 0 follows the left end, 1 the right end
        logic last;    // last pass of its item
        logic done;    // descent has already passed a leaf
        logic tgt_en;  // add into the target node at this level
    } ctrl_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SIDE_B,
        ST_WAIT
    } state_t;

endpackage

@@ src/rapqt_cell.sv @@
`timescale 1ns / 1ps
// One tree level: node storage for that level plus the descent step to the next.
// Depends on rapqt_pkg for the control word and the item kinds.
module rapqt_cell
    import rapqt_pkg::*;
#(
    parameter int LEVEL = 0,
    parameter int PW    = 11,
    parameter int NW    = 11,
    parameter int CW    = 10
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              clr_en,
    input  logic [CW-1:0]     clr_addr,
    input  ctrl_t             in_ctrl,
    input  logic [NW-1:0]     in_v,
    input  logic [PW-1:0]     in_lo,
    input  logic [PW-1:0]     in_hi,
    input  logic [NW-1:0]     in_tgt,
    input  logic [AMT_W-1:0]  in_sum,
    input  logic [AMT_W-1:0]  in_amount,
    input  logic [PW-1:0]     in_ql,
    input  logic [PW-1:0]     in_qr,
    output ctrl_t             out_ctrl,
    output logic [NW-1:0]     out_v,
    output logic [PW-1:0]     out_lo,
    output logic [PW-1:0]     out_hi,
    output logic [NW-1:0]     out_tgt,
    output logic [AMT_W-1:0]  out_sum,
    output logic [AMT_W-1:0]  out_amount,
    output logic [PW-1:0]     out_ql,
    output logic [PW-1:0]     out_qr
);

    // Level 0 keeps a two-entry array so the index never has zero width.
    localparam int IW    = (LEVEL > 0) ? LEVEL : 1;
    localparam int MEM_D = 1 << IW;

    logic [AMT_W-1:0] mem [0:MEM_D-1];

    ctrl_t            ctrl_reg;
    logic [NW-1:0]    v_reg;
    logic [PW-1:0]    lo_reg;
    logic [PW-1:0]    hi_reg;
    logic [NW-1:0]    tgt_reg;
    logic [AMT_W-1:0] sum_reg;
    logic [AMT_W-1:0] amount_reg;
    logic [PW-1:0]    ql_reg;
    logic [PW-1:0]    qr_reg;
    logic [AMT_W-1:0] rd_reg;

    logic             is_leaf;
    logic             live;
    logic [PW:0]      span_sum;
    logic [PW-1:0]    mid;
    logic [PW-1:0]    mid_p1;
    logic [PW-1:0]    path_pos;
    logic             go_right;
    logic             has_ql;
    logic             has_qr;
    logic             owned;
    logic             covered;
    logic             left_full;
    logic             right_full;
    logic             split;
    logic [NW-1:0]    child_l;
    logic [NW-1:0]    child_r;
    logic [NW-1:0]    path_child;
    logic             wr_en;
    logic             op_wr;
    logic [IW-1:0]    wr_addr;
    logic [AMT_W-1:0] wr_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else
        begin
            ctrl_reg <= in_ctrl;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg      <= in_v;
        lo_reg     <= in_lo;
        hi_reg     <= in_hi;
        tgt_reg    <= in_tgt;
        sum_reg    <= in_sum;
        amount_reg <= in_amount;
        ql_reg     <= in_ql;
        qr_reg     <= in_qr;
    end

    // The read address arrives with the item, so the word is ready when it lands here.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_reg <= mem[in_tgt[IW-1:0]];
    end

    always_comb
    begin
        is_leaf    = lo_reg >= hi_reg;
        live       = ctrl_reg.valid && !ctrl_reg.done;
        span_sum   = {1'b0, lo_reg} + {1'b0, hi_reg};
        mid        = span_sum[PW:1];
        mid_p1     = mid + PW'(1);
        path_pos   = ctrl_reg.side ? qr_reg : ql_reg;
        go_right   = path_pos > mid;
        has_ql     = (ql_reg >= lo_reg) && (ql_reg <= hi_reg);
        has_qr     = (qr_reg >= lo_reg) && (qr_reg <= hi_reg);
        // A partial node is handled by the pass of the left end when it holds it,
        // otherwise by the pass of the right end.
        owned      = ctrl_reg.side ? (has_qr && !has_ql) : has_ql;
        covered    = (ql_reg <= lo_reg) && (hi_reg <= qr_reg);
        left_full  = (ql_reg <= lo_reg) && (mid <= qr_reg);
        right_full = (ql_reg <= mid_p1) && (hi_reg <= qr_reg);
        split      = live && (ctrl_reg.op == OP_ADD) && !is_leaf && owned && !covered;
        child_l    = {v_reg[NW-2:0], 1'b0};
        child_r    = {v_reg[NW-2:0], 1'b1};
        path_child = go_right ? child_r : child_l;
    end

    always_comb
    begin
        op_wr   = 1'b0;
        wr_addr = clr_addr[IW-1:0];
        wr_data = '0;
        if (live && (ctrl_reg.op == OP_LOAD) && is_leaf)
        begin
            op_wr   = 1'b1;
            wr_addr = v_reg[IW-1:0];
            wr_data = amount_reg;
        end
        else if (ctrl_reg.valid && ctrl_reg.tgt_en)
        begin
            op_wr   = 1'b1;
            wr_addr = tgt_reg[IW-1:0];
            wr_data = rd_reg + amount_reg;
        end
        if (clr_en)
        begin
            wr_addr = clr_addr[IW-1:0];
            wr_data = '0;
        end
        wr_en = op_wr || clr_en;
    end

    always_comb
    begin
        out_ctrl        = ctrl_reg;
        out_ctrl.done   = ctrl_reg.done || is_leaf;
        out_ctrl.tgt_en = split && (left_full || right_full);
        out_v           = path_child;
        out_lo          = go_right ? mid_p1 : lo_reg;
        out_hi          = go_right ? hi_reg : mid;
        if (split)
        begin
            out_tgt = left_full ? child_l : child_r;
        end
        else
        begin
            out_tgt = path_child;
        end
        if (live && (ctrl_reg.op == OP_GET))
        begin
            out_sum = sum_reg + rd_reg;
        end
        else
        begin
            out_sum = sum_reg;
        end
        out_amount = amount_reg;
        out_ql     = ql_reg;
        out_qr     = qr_reg;
    end

    a_no_item_write_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clr_en |-> !op_wr)
        else $error("item write during clearing pass");

    a_target_only_for_add: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl_reg.valid && ctrl_reg.tgt_en) |-> (ctrl_reg.op == OP_ADD && !ctrl_reg.done))
        else $error("node target on a non-add item or past a leaf");

    a_finished_item_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl_reg.valid && ctrl_reg.done) |-> (!op_wr && out_sum == sum_reg))
        else $error("item acts after its descent has ended");

    a_split_child_target: assert property (@(posedge clk) disable iff (!rst_n)
        (split && left_full) |-> !right_full)
        else $error("both children of a partial node are covered");

endmodule

@@ src/range_add_point_query_tree_core.sv @@
`timescale 1ns / 1ps
// Segment tree with range add and point query: a chain of one cell per tree level.
// A get result enters the two-entry result queue when its item leaves the chain; loads and
// gets pass down the chain once, adds twice (one pass per end of the interval), and no new
// item is taken until the last pass has left. Items that change nothing are dropped when
// taken and need no pass. After reset a clearing pass zeroes every level memory with
// s_tready low.
module range_add_point_query_tree_core
    import rapqt_pkg::*;
#(
    parameter int LEAVES = 1024
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [IN_DATA_W-1:0] s_tdata,   // left_pos[10:0], right_pos[21:11], amount[85:22]
    input  logic [1:0]           s_tuser,   // kind
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [AMT_W-1:0]     m_tdata    // element_value
);

    localparam int DEPTH = $clog2(LEAVES) + 1;
    localparam int LW    = $clog2(LEAVES + 1);
    localparam int PW    = (LW > POS_W) ? LW : POS_W;
    localparam int NW    = DEPTH;
    localparam int CW    = (DEPTH > 2) ? DEPTH - 1 : 1;
    localparam logic [PW-1:0] LAST_POS = PW'(LEAVES);

    state_t           state_reg;
    state_t           state_next;
    logic [CW-1:0]    clr_cnt_reg;
    logic [PW-1:0]    qlb_reg;
    logic [PW-1:0]    qrb_reg;
    logic [AMT_W-1:0] amtb_reg;
    logic [AMT_W-1:0] q0_reg;
    logic [AMT_W-1:0] q1_reg;
    logic [1:0]       cnt_reg;

    ctrl_t            st_ctrl   [0:DEPTH];
    logic [NW-1:0]    st_v      [0:DEPTH];
    logic [PW-1:0]    st_lo     [0:DEPTH];
    logic [PW-1:0]    st_hi     [0:DEPTH];
    logic [NW-1:0]    st_tgt    [0:DEPTH];
    logic [AMT_W-1:0] st_sum    [0:DEPTH];
    logic [AMT_W-1:0] st_amount [0:DEPTH];
    logic [PW-1:0]    st_ql     [0:DEPTH];
    logic [PW-1:0]    st_qr     [0:DEPTH];

    logic [PW-1:0]    ql_ext;
    logic [PW-1:0]    qr_ext;
    logic [PW-1:0]    ql_c;
    logic [PW-1:0]    qr_c;
    logic [AMT_W-1:0] in_amount;
    op_t              in_op;
    logic             kind_ok;
    logic             drop;
    logic             take;
    logic             issue;
    logic             clr_en;
    logic             exit_last;
    logic             push;
    logic             pop;

    always_comb
    begin
        ql_ext    = PW'(s_tdata[LEFT_LSB +: POS_W]);
        qr_ext    = PW'(s_tdata[RIGHT_LSB +: POS_W]);
        in_amount = s_tdata[AMT_LSB +: AMT_W];
        kind_ok   = s_tuser != KIND_UNUSED;
        in_op     = op_t'(s_tuser);
        // Clamp the interval to the leaves; spans never reach outside them.
        ql_c      = (ql_ext == '0) ? PW'(1) : ql_ext;
        qr_c      = (qr_ext > LAST_POS) ? LAST_POS : qr_ext;
        drop      = !kind_ok
                 || ((in_op == OP_LOAD) && ((ql_ext == '0) || (ql_ext > LAST_POS)))
                 || ((in_op == OP_ADD) && (ql_c > qr_c));
        take      = s_tvalid && s_tready;
        issue     = take && !drop;
        exit_last = st_ctrl[DEPTH].valid && st_ctrl[DEPTH].last;
        push      = st_ctrl[DEPTH].valid && (st_ctrl[DEPTH].op == OP_GET);
        pop       = m_tvalid && m_tready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (clr_en)
            begin
                clr_cnt_reg <= clr_cnt_reg + CW'(1);
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (issue)
                begin
                    state_next = (in_op == OP_ADD) ? ST_SIDE_B : ST_WAIT;
                end
            end
            ST_SIDE_B:
            begin
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (exit_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        s_tready = 1'b0;
        clr_en   = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_en = 1'b1;
            end
            ST_IDLE:
            begin
                // A get that enters now always finds room in the result queue.
                s_tready = cnt_reg != 2'd2;
            end
            ST_SIDE_B,
            ST_WAIT:
            begin
                s_tready = 1'b0;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    // The right-end pass of an add reuses the clamped interval held here.
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            qlb_reg  <= ql_c;
            qrb_reg  <= qr_c;
            amtb_reg <= in_amount;
        end
    end

    always_comb
    begin
        st_ctrl[0]   = '0;
        st_v[0]      = NW'(1);
        st_lo[0]     = PW'(1);
        st_hi[0]     = LAST_POS;
        st_tgt[0]    = NW'(1);
        st_sum[0]    = '0;
        st_amount[0] = in_amount;
        st_ql[0]     = (in_op == OP_ADD) ? ql_c : ql_ext;
        st_qr[0]     = qr_c;
        if (state_reg == ST_SIDE_B)
        begin
            st_ctrl[0].valid = 1'b1;
            st_ctrl[0].op    = OP_ADD;
            st_ctrl[0].side  = 1'b1;
            st_ctrl[0].last  = 1'b1;
            st_amount[0]     = amtb_reg;
            st_ql[0]         = qlb_reg;
            st_qr[0]         = qrb_reg;
        end
        else if (issue)
        begin
            st_ctrl[0].valid  = 1'b1;
            st_ctrl[0].op     = in_op;
            st_ctrl[0].last   = in_op != OP_ADD;
            st_ctrl[0].tgt_en = (in_op == OP_ADD) && (ql_c == PW'(1)) && (qr_c == LAST_POS);
        end
    end

    for (genvar g = 0; g < DEPTH; g++)
    begin : g_level
        rapqt_cell #(
            .LEVEL (g),
            .PW    (PW),
            .NW    (NW),
            .CW    (CW)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .clr_en     (clr_en),
            .clr_addr   (clr_cnt_reg),
            .in_ctrl    (st_ctrl[g]),
            .in_v       (st_v[g]),
            .in_lo      (st_lo[g]),
            .in_hi      (st_hi[g]),
            .in_tgt     (st_tgt[g]),
            .in_sum     (st_sum[g]),
            .in_amount  (st_amount[g]),
            .in_ql      (st_ql[g]),
            .in_qr      (st_qr[g]),
            .out_ctrl   (st_ctrl[g+1]),
            .out_v      (st_v[g+1]),
            .out_lo     (st_lo[g+1]),
            .out_hi     (st_hi[g+1]),
            .out_tgt    (st_tgt[g+1]),
            .out_sum    (st_sum[g+1]),
            .out_amount (st_amount[g+1]),
            .out_ql     (st_ql[g+1]),
            .out_qr     (st_qr[g+1])
        );
    end

    // Two-entry result queue; the head sits in q0_reg.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else if (push && !pop)
        begin
            cnt_reg <= cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            cnt_reg <= cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && pop)
        begin
            if (cnt_reg == 2'd1)
            begin
                q0_reg <= st_sum[DEPTH];
            end
            else
            begin
                q0_reg <= q1_reg;
                q1_reg <= st_sum[DEPTH];
            end
        end
        else if (push)
        begin
            if (cnt_reg == 2'd0)
            begin
                q0_reg <= st_sum[DEPTH];
            end
            else
            begin
                q1_reg <= st_sum[DEPTH];
            end
        end
        else if (pop)
        begin
            q0_reg <= q1_reg;
        end
    end

    assign m_tvalid = cnt_reg != 2'd0;
    assign m_tdata  = q0_reg;

    a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (cnt_reg != 2'd2 || pop))
        else $error("result leaves the chain with the queue full");

    a_exit_while_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        st_ctrl[DEPTH].valid |-> (state_reg == ST_WAIT))
        else $error("item leaves the chain outside the wait state");

    a_right_pass_after_add: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SIDE_B) |-> ($past(state_reg) == ST_IDLE && $past(issue)))
        else $error("right-end pass without a preceding add");

endmodule

@@ verif/tree_sum_checker.sv @@
`timescale 1ns / 1ps
// Checker for range_add_point_query_tree_core: keeps a copy of the segment tree,
// predicts every element value a get returns and compares it with the output stream.
// Depends on rapqt_pkg for field offsets, widths and item kinds.
module tree_sum_checker
    import rapqt_pkg::*;
#(
    parameter int LEAVES = 1024
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [IN_DATA_W-1:0] s_tdata,   // left_pos, right_pos, amount
    input  logic [1:0]           s_tuser,   // kind
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [AMT_W-1:0]     m_tdata,   // element_value
    output int                   mismatches,
    output int                   results_checked,
    output int                   outstanding
);

    localparam int NODE_COUNT = 4 * LEAVES;

    logic [AMT_W-1:0] tree_node [0:NODE_COUNT-1];
    logic [AMT_W-1:0] expected_values [$];
    int               error_tally;
    int               checked_tally;

    // Walk from the root towards a position; positions outside the leaves saturate.
    // With accumulate set, the node values on the path are summed on the way down.
    function automatic logic [AMT_W-1:0] descend(input int unsigned pos, input bit accumulate,
                                                 output int unsigned leaf_node);
        int unsigned      v;
        int unsigned      lo;
        int unsigned      hi;
        int unsigned      mid;
        logic [AMT_W-1:0] sum;
        v   = 1;
        lo  = 1;
        hi  = LEAVES;
        sum = '0;
        forever
        begin
            if (accumulate)
                sum = sum + tree_node[v];
            if (lo >= hi)
                break;
            mid = (lo + hi) / 2;
            if (pos <= mid)
            begin
                v  = 2 * v;
                hi = mid;
            end
            else
            begin
                v  = 2 * v + 1;
                lo = mid + 1;
            end
        end
        leaf_node = v;
        return sum;
    endfunction

    // Add to every maximal node covered by [ql,qr], using an explicit work stack.
    task automatic interval_add(input int unsigned ql, input int unsigned qr,
                                input logic [AMT_W-1:0] amt);
        int unsigned stk_node [0:63];
        int unsigned stk_lo   [0:63];
        int unsigned stk_hi   [0:63];
        int          sp;
        int unsigned v;
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        if (ql > qr)
            return;
        sp          = 1;
        stk_node[0] = 1;
        stk_lo[0]   = 1;
        stk_hi[0]   = LEAVES;
        while (sp > 0)
        begin
            sp = sp - 1;
            v  = stk_node[sp];
            lo = stk_lo[sp];
            hi = stk_hi[sp];
            if (lo > hi || lo > qr || hi < ql)
                continue;
            if (lo >= ql && hi <= qr)
            begin
                tree_node[v] = tree_node[v] + amt;
                continue;
            end
            mid          = (lo + hi) / 2;
            stk_node[sp] = 2 * v;
            stk_lo[sp]   = lo;
            stk_hi[sp]   = mid;
            sp           = sp + 1;
            stk_node[sp] = 2 * v + 1;
            stk_lo[sp]   = mid + 1;
            stk_hi[sp]   = hi;
            sp           = sp + 1;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        int unsigned      lp;
        int unsigned      rp;
        int unsigned      leaf;
        logic [AMT_W-1:0] amt;
        logic [AMT_W-1:0] want;
        if (!rst_n)
        begin
            for (int i = 0; i < NODE_COUNT; i++)
                tree_node[i] = '0;
            expected_values.delete();
            error_tally     = 0;
            checked_tally   = 0;
            mismatches      <= 0;
            results_checked <= 0;
            outstanding     <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_values.size() == 0)
                begin
                    $error("element_value: no result expected, actual %h", m_tdata);
                    error_tally = error_tally + 1;
                end
                else
                begin
                    want = expected_values.pop_front();
                    checked_tally = checked_tally + 1;
                    if (m_tdata !== want)
                    begin
                        $error("element_value mismatch: expected %h, actual %h", want, m_tdata);
                        error_tally = error_tally + 1;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                lp  = 32'(s_tdata[LEFT_LSB +: POS_W]);
                rp  = 32'(s_tdata[RIGHT_LSB +: POS_W]);
                amt = s_tdata[AMT_LSB +: AMT_W];
                case (s_tuser)
                    OP_LOAD:
                    begin
                        // A load replaces the leaf node only; ancestors keep their adds.
                        if (lp >= 1 && lp <= LEAVES)
                        begin
                            void'(descend(lp, 1'b0, leaf));
                            tree_node[leaf] = amt;
                        end
                    end
                    OP_ADD:
                        interval_add(lp, rp, amt);
                    OP_GET:
                        expected_values.push_back(descend(lp, 1'b1, leaf));
                    default:
                        ;
                endcase
            end
            mismatches      <= error_tally;
            results_checked <= checked_tally;
            outstanding     <= expected_values.size();
        end
    end

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// Top of the range_add_point_query_tree_core testbench: clock, reset, stimulus and verdict.
// Depends on rapqt_pkg, the core and tree_sum_checker, which predicts and compares.
module tb_top;
    import rapqt_pkg::*;

    localparam int LEAVES       = 1024;
    localparam int LEVELS       = $clog2(LEAVES) + 1;
    localparam int RANDOM_ITEMS = 600;
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 5000;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [IN_DATA_W-1:0] s_tdata;   // left_pos[10:0], right_pos[21:11], amount[85:22]
    logic [1:0]           s_tuser;   // kind
    logic                 m_tvalid;
    logic                 m_tready;
    logic [AMT_W-1:0]     m_tdata;   // element_value

    int mismatches;
    int results_checked;
    int outstanding;

    bit src_idle_on  = 1'b1;
    bit sink_idle_on = 1'b1;
    bit hold_req     = 1'b0;
    int idle_cycles  = 0;

    int loads_done   = 0;
    int adds_done    = 0;
    int gets_done    = 0;
    int ignored_done = 0;
    int window_base  = 1;

    range_add_point_query_tree_core #(.LEAVES(LEAVES)) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    tree_sum_checker #(.LEAVES(LEAVES)) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .mismatches      (mismatches),
        .results_checked (results_checked),
        .outstanding     (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Any accepted item on either side restarts the count.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("range_add_point_query_tree_core test failed");
                $finish;
            end
        end
    end

    // Result side: random stall bursts, plus one long hold-off on request.
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                m_tready <= 1'b1;
                hold_req = 1'b0;
            end
            else if (sink_idle_on && $urandom_range(0, 5) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
                m_tready <= 1'b1;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic send_item(input logic [1:0] kind, input logic [POS_W-1:0] lp,
                             input logic [POS_W-1:0] rp, input logic [AMT_W-1:0] amt);
        logic [IN_DATA_W-1:0] word;
        word = '0;
        word[LEFT_LSB +: POS_W]  = lp;
        word[RIGHT_LSB +: POS_W] = rp;
        word[AMT_LSB +: AMT_W]   = amt;
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        s_tuser  <= kind;
        do
            @(posedge clk);
        while (!s_tready);
        if (kind == OP_GET)
            gets_done++;
        else if (kind == OP_LOAD && lp >= 1 && lp <= LEAVES)
            loads_done++;
        else if (kind == OP_ADD && lp <= rp && rp >= 1 && lp <= LEAVES)
            adds_done++;
        else
            ignored_done++;
        if (src_idle_on && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
    endtask

    function automatic logic [POS_W-1:0] pick_pos();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 40)
            return POS_W'(window_base + $urandom_range(0, 15));
        else if (sel < 85)
            return POS_W'($urandom_range(1, LEAVES));
        else if (sel < 95)
            return POS_W'($urandom_range(0, 2047));
        case ($urandom_range(0, 4))
            0: return POS_W'(0);
            1: return POS_W'(1);
            2: return POS_W'(LEAVES);
            3: return POS_W'(LEAVES + 1);
            default: return '1;
        endcase
    endfunction

    function automatic logic [AMT_W-1:0] pick_amount();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 50)
            return {$urandom, $urandom};
        else if (sel < 70)
            return AMT_W'($urandom_range(0, 15));
        else if (sel < 85)
            return '1 - AMT_W'($urandom_range(0, 15));
        return AMT_W'(1) << $urandom_range(0, AMT_W - 1);
    endfunction

    task automatic send_random_item();
        logic [1:0]       kind;
        logic [POS_W-1:0] lp;
        logic [POS_W-1:0] rp;
        logic [POS_W-1:0] tmp;
        int               sel;
        sel = $urandom_range(0, 99);
        lp  = pick_pos();
        rp  = pick_pos();
        if (sel < 12)
            kind = OP_LOAD;
        else if (sel < 50)
        begin
            kind = OP_ADD;
            // Mostly well-formed intervals; the rest stay empty.
            if (lp > rp && $urandom_range(0, 3) != 0)
            begin
                tmp = lp;
                lp  = rp;
                rp  = tmp;
            end
        end
        else if (sel < 96)
            kind = OP_GET;
        else
            kind = KIND_UNUSED;
        send_item(kind, lp, rp, pick_amount());
    endtask

    initial
    begin
        int effective;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = OP_LOAD;
        @(posedge rst_n);

        // Directed part: extremes, empty and outside intervals, saturation, unknown kind.
        send_item(OP_GET,      11'd1,    11'd0,    '0);
        send_item(OP_LOAD,     11'd1,    11'd0,    '1);
        send_item(OP_LOAD,     11'd1024, 11'd2047, 64'h8000_0000_0000_0000);
        send_item(OP_LOAD,     11'd0,    11'd0,    64'h1234);
        send_item(OP_LOAD,     11'd1025, 11'd0,    64'h5678);
        send_item(OP_LOAD,     11'd2047, 11'd0,    64'h9abc);
        send_item(OP_GET,      11'd1,    11'd0,    '0);
        send_item(OP_GET,      11'd1024, 11'd0,    '0);
        send_item(OP_ADD,      11'd1,    11'd1024, 64'd1);
        send_item(OP_ADD,      11'd5,    11'd3,    64'd77);
        send_item(OP_ADD,      11'd1000, 11'd2047, '1);
        send_item(OP_ADD,      11'd0,    11'd0,    64'd99);
        send_item(OP_ADD,      11'd0,    11'd5,    64'd2);
        send_item(OP_ADD,      11'd1025, 11'd2047, 64'd3);
        send_item(KIND_UNUSED, 11'h7ff,  11'h7ff,  '1);
        send_item(OP_GET,      11'd0,    11'd0,    '0);
        send_item(OP_GET,      11'd2047, 11'd0,    '0);
        send_item(OP_GET,      11'd3,    11'd0,    '0);
        send_item(OP_GET,      11'd1000, 11'd0,    '0);
        send_item(OP_GET,      11'd513,  11'd1024, '1);
        send_item(OP_LOAD,     11'd1,    11'd0,    64'd5);
        send_item(OP_GET,      11'd1,    11'd0,    '0);
        send_item(OP_GET,      11'd1024, 11'd0,    '0);

        effective = 0;
        while (effective < RANDOM_ITEMS)
        begin
            if (effective % 50 == 0)
                window_base = $urandom_range(1, LEAVES - 15);
            if (effective == RANDOM_ITEMS / 2)
            begin
                // Hold the result side off while gets keep coming, so the chain backs up.
                src_idle_on = 1'b0;
                hold_req    = 1'b1;
                for (int i = 0; i < 40; i++)
                    send_item(OP_GET, pick_pos(), pick_pos(), '0);
                src_idle_on = 1'b1;
            end
            if (effective == RANDOM_ITEMS - 100)
            begin
                src_idle_on  = 1'b0;
                sink_idle_on = 1'b0;
            end
            send_random_item();
            effective = loads_done + adds_done + gets_done - 16;
        end
        s_tvalid <= 1'b0;

        while (outstanding != 0)
            @(posedge clk);
        repeat (LEVELS + 8) @(posedge clk);

        $display("Covered %0d loads, %0d adds, %0d gets and %0d items without effect;",
                 loads_done, adds_done, gets_done, ignored_done);
        $display("%0d element values compared, including a %0d-cycle result-side hold-off.",
                 results_checked, HOLD_CYCLES);
        if (mismatches == 0 && outstanding == 0)
            $display("range_add_point_query_tree_core test passed");
        else
            $display("range_add_point_query_tree_core test failed");
        $finish;
    end

endmodule
